### hdl/error_diffusion_dither_defines.svh
// Assertion macros for the checker file of the dither block.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// Same-cycle implication.
`define ED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ed_pkg.sv
package ed_pkg;

  localparam int NUM_LANES    = 4;
  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 8;
  localparam int ROW_W_BITS   = 13;
  localparam int CHAN_BITS    = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int DIV_STEPS    = 16;
  localparam int DIV_CNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL_B   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL_C   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL_D   = 3'd5;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
    logic                in_final_row;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_c;
    logic [LEVEL_W-1:0] level_d;
    logic               row_end;
  } out_word_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic tgt_en;
    logic lvl_en;
    logic div_load;
    logic div_step;
    logic wr_a;
    logic wr_b;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_wra;
  } ctrl_sts_t;

endpackage

### hdl/ed_if.sv
interface ed_in_if;
  logic             valid;
  logic             ready;
  ed_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ed_out_if;
  logic              valid;
  logic              ready;
  ed_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/ed_ctrl.sv
module ed_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ed_pkg::ctrl_sts_t sts,
  output ed_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TGT   = 3'd2;
  localparam logic [2:0] S_LVL   = 3'd3;
  localparam logic [2:0] S_DLOAD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_WRA   = 3'd6;
  localparam logic [2:0] S_WRB   = 3'd7;

  localparam logic [ed_pkg::DIV_CNT_W-1:0] DIV_LAST = ed_pkg::DIV_CNT_W'(ed_pkg::DIV_STEPS - 1);

  logic [2:0]                   state_r, state_nxt;
  logic [ed_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        cmd.tgt_en = 1'b1;
        state_nxt  = S_LVL;
      end
      S_LVL: begin
        cmd.lvl_en = 1'b1;
        state_nxt  = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) state_nxt = sts.need_wra ? S_WRA : S_WRB;
      end
      S_WRA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        // Commit only once the output register can take the new word.
        if (out_free) begin
          cmd.wr_b  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.wr_b) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/ed_dp.sv
module ed_dp #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ed_pkg::ctrl_cmd_t               cmd,
  output ed_pkg::ctrl_sts_t               sts,
  input  ed_pkg::in_word_t                in_data,
  output ed_pkg::out_word_t               out_data,
  input  logic                            cfg_we,
  input  logic [ed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ed_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NL    = ed_pkg::NUM_LANES;
  localparam int SW    = ed_pkg::SAMPLE_W;
  localparam int LW    = ed_pkg::LEVEL_W;

  // Configuration.
  logic [ed_pkg::ROW_W_BITS-1:0] row_width_r;
  logic [ed_pkg::CHAN_BITS-1:0]  chan_cnt_r;
  logic [NL-1:0][LW-1:0]         max_lvl_r;

  // Line store.
  logic [NL*SW-1:0] mem [MAX_WIDTH];
  logic [NL-1:0][SW-1:0] rd_r;
  logic             mem_we;
  logic [COL_W-1:0] mem_wa;
  logic [NL*SW-1:0] mem_wd;
  logic [COL_W-1:0] clr_cnt_r;

  // Row state.
  logic [COL_W-1:0]      col_r;
  logic [NL-1:0][SW-1:0] rc_r, blp_r, bp_r;

  // Item being worked on.
  logic [NL-1:0][SW-1:0]        smp_r;
  logic                         fin_r;
  logic [NL-1:0][17:0]          tgt_r;
  logic [NL-1:0][LW-1:0]        lvl_r;
  logic [NL-1:0][9:0]           rem_r;
  logic [NL-1:0][SW-1:0]        num_r;
  ed_pkg::out_word_t            out_r;

  logic [17:0]           width_eff;
  logic [17:0]           col_p1;
  logic                  last;
  logic [ed_pkg::CHAN_BITS-1:0] nch;
  logic [NL-1:0]         lane_en;
  logic [NL-1:0][LW-1:0] m_eff;
  logic [NL-1:0][17:0]   tgt_nxt;
  logic [NL-1:0][LW-1:0] lvl_nxt;
  logic [NL-1:0][9:0]    rem_ld, rem_st;
  logic [NL-1:0][SW-1:0] num_ld, num_st;
  logic [NL-1:0][SW-1:0] eu, rc_w, prev_w, nbl_w, nbp_w;

  always_comb begin
    if (row_width_r == '0) width_eff = 18'd1;
    else if (18'(row_width_r) > 18'(MAX_WIDTH)) width_eff = 18'(MAX_WIDTH);
    else width_eff = 18'(row_width_r);
    col_p1 = 18'(col_r) + 18'd1;
    last   = (col_p1 >= width_eff);
    if (chan_cnt_r == '0) nch = 3'd1;
    else if (chan_cnt_r > 3'(ed_pkg::MAX_CHANNELS)) nch = 3'(ed_pkg::MAX_CHANNELS);
    else nch = chan_cnt_r;
  end

  assign sts.clr_done = (clr_cnt_r == COL_W'(MAX_WIDTH - 1));
  assign sts.need_wra = fin_r || last;

  always_comb begin
    logic [SW-1:0] acc;
    logic [SW-1:0] sh;
    logic [23:0]   x;
    logic [24:0]   z;
    logic [16:0]   s;
    logic [8:0]    q;
    logic [25:0]   n;
    logic [9:0]    tr;
    logic [9:0]    dv;
    for (int c = 0; c < NL; c++) begin
      lane_en[c] = (3'(c) < nch);
      m_eff[c]   = (max_lvl_r[c] == '0) ? 8'd1 : max_lvl_r[c];

      // Target: sample plus accumulated error, arithmetic shift by four.
      acc        = rd_r[c] + rc_r[c];
      sh         = SW'($signed(acc) >>> 4);
      tgt_nxt[c] = {2'b00, smp_r[c]} + {{2{sh[SW-1]}}, sh};

      // Round half up of t*m/65535: split the sum into 64K digits, since
      // 65536 is one more than the divisor the low digit needs one fix-up.
      x = tgt_r[c][15:0] * m_eff[c];
      z = 25'(x) + 25'd32767;
      s = 17'(z[24:16]) + 17'(z[15:0]);
      q = z[24:16] + 9'((s >= 17'd65535) ? 1 : 0);
      if (tgt_r[c][17]) lvl_nxt[c] = '0;
      else if (tgt_r[c][16]) lvl_nxt[c] = m_eff[c];
      else lvl_nxt[c] = q[7:0];

      // Reconstruction numerator; its quotient by 2m fits in 16 bits.
      n          = {1'b0, lvl_r[c], 17'd0} - {17'd0, lvl_r[c], 1'b0} + 26'(m_eff[c]);
      rem_ld[c]  = n[25:16];
      num_ld[c]  = n[15:0];

      dv = {1'b0, m_eff[c], 1'b0};
      tr = {rem_r[c][8:0], num_r[c][SW-1]};
      if (tr >= dv) begin
        rem_st[c] = tr - dv;
        num_st[c] = {num_r[c][SW-2:0], 1'b1};
      end else begin
        rem_st[c] = tr;
        num_st[c] = {num_r[c][SW-2:0], 1'b0};
      end

      eu[c] = tgt_r[c][15:0] - num_r[c];
      if (lane_en[c]) begin
        rc_w[c]   = (eu[c] << 3) - eu[c];
        prev_w[c] = blp_r[c] + (eu[c] << 1) + eu[c];
        nbl_w[c]  = bp_r[c] + (eu[c] << 2) + eu[c];
        nbp_w[c]  = eu[c];
      end else begin
        rc_w[c]   = '0;
        prev_w[c] = '0;
        nbl_w[c]  = '0;
        nbp_w[c]  = '0;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = col_r;
    mem_wd = '0;
    if (cmd.clr_en) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
    end else if (cmd.wr_a) begin
      mem_we = 1'b1;
      mem_wd = fin_r ? '0 : nbl_w;
    end else if (cmd.wr_b && (col_r != '0)) begin
      mem_we = 1'b1;
      mem_wa = col_r - 1'b1;
      mem_wd = fin_r ? '0 : prev_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.load) rd_r <= mem[col_r];
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r[0] <= in_data.sample_a;
      smp_r[1] <= in_data.sample_b;
      smp_r[2] <= in_data.sample_c;
      smp_r[3] <= in_data.sample_d;
      fin_r    <= in_data.in_final_row;
    end
    if (cmd.tgt_en) tgt_r <= tgt_nxt;
    if (cmd.lvl_en) lvl_r <= lvl_nxt;
    if (cmd.div_load) begin
      rem_r <= rem_ld;
      num_r <= num_ld;
    end else if (cmd.div_step) begin
      rem_r <= rem_st;
      num_r <= num_st;
    end
    if (cmd.wr_b) begin
      out_r.level_a <= lane_en[0] ? lvl_r[0] : '0;
      out_r.level_b <= lane_en[1] ? lvl_r[1] : '0;
      out_r.level_c <= lane_en[2] ? lvl_r[2] : '0;
      out_r.level_d <= lane_en[3] ? lvl_r[3] : '0;
      out_r.row_end <= last;
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= 13'd4096;
      chan_cnt_r  <= 3'd3;
      max_lvl_r   <= {NL{8'd255}};
      col_r       <= '0;
      rc_r        <= '0;
      blp_r       <= '0;
      bp_r        <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ed_pkg::CFG_ROW_WIDTH:     row_width_r  <= cfg_data;
          ed_pkg::CFG_CHANNEL_COUNT: chan_cnt_r   <= cfg_data[2:0];
          ed_pkg::CFG_MAX_LEVEL_A:   max_lvl_r[0] <= cfg_data[7:0];
          ed_pkg::CFG_MAX_LEVEL_B:   max_lvl_r[1] <= cfg_data[7:0];
          ed_pkg::CFG_MAX_LEVEL_C:   max_lvl_r[2] <= cfg_data[7:0];
          ed_pkg::CFG_MAX_LEVEL_D:   max_lvl_r[3] <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.wr_b) begin
        if (last) begin
          col_r <= '0;
          rc_r  <= '0;
          blp_r <= '0;
          bp_r  <= '0;
        end else begin
          col_r <= col_r + 1'b1;
          rc_r  <= rc_w;
          blp_r <= fin_r ? '0 : nbl_w;
          bp_r  <= fin_r ? '0 : nbp_w;
        end
      end
    end
  end

endmodule

### hdl/error_diffusion_dither.sv
// Error-diffusion dither, one pixel of up to four 16-bit channels per word.
// Input words arrive on in_ch in row-major order, with in_final_row set for
// every pixel of the frame's last row. Each accepted input word yields one
// output word on out_ch with a quantized level per channel and row_end on
// the last pixel of a row. Both channels use a valid/ready handshake.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block does not enforce this. After reset all
// MAX_WIDTH line-store entries are cleared, one entry a cycle; in_ch.ready
// stays low during that pass. Registers reset to a row width of 4096, three
// channels and a highest level of 255. A pixel passes through the states
// target, level, divider load, the 16-step reconstruction divide, an extra
// line-store write on the last pixel of a row or in the final row, and the
// result write. The divider makes one quotient bit per cycle for all channels
// at once. The output word sits in an output register; a new word is accepted
// while it waits, and a stalled receiver holds the block only at the point
// where the next result would be written.
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ed_in_if.sink                         in_ch,
  ed_out_if.source                      out_ch,
  input  logic                          cfg_we,
  input  logic [ed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ed_pkg::CFG_DATA_W-1:0] cfg_data
);

  ed_pkg::ctrl_cmd_t cmd;
  ed_pkg::ctrl_sts_t sts;

  ed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ed_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### hdl/ed_chk.sv
`include "error_diffusion_dither_defines.svh"

module ed_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ed_pkg::out_word_t out_data
);

  `ED_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")
  `ED_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled output changed")
  // One pixel at a time: the input closes right after an accept.
  `ED_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second word taken while busy")
  // A result never appears in the cycle right after an accept.
  `ED_ASSERT_NXT(a_no_early, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind error_diffusion_dither ed_chk u_ed_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

### sim/tb_ed_if.sv
`timescale 1ns / 1ps

### sim/tb_error_diffusion_dither.sv
`timescale 1ns / 1ps

module tb_error_diffusion_dither;

  localparam int LINE_DEPTH = 4096;
  localparam int STALL_LIMIT = 20000;

  // Tracks the dither state and queues the levels expected for each word.
  class dither_scoreboard;
    bit [15:0] err_line [LINE_DEPTH][4];
    bit [15:0] carry_right [4];
    bit [15:0] part_below_left [4];
    bit [15:0] part_below [4];
    int unsigned col_pos;
    int unsigned width_reg;
    int unsigned chan_reg;
    int unsigned max_reg [4];
    ed_pkg::out_word_t levels_due [$];
    int unsigned mismatches;
    int unsigned words_checked;

    function void clear();
      foreach (err_line[i, c]) err_line[i][c] = '0;
      for (int c = 0; c < 4; c++) begin
        carry_right[c] = '0;
        part_below_left[c] = '0;
        part_below[c] = '0;
        max_reg[c] = 255;
      end
      col_pos = 0;
      width_reg = 4096;
      chan_reg = 3;
      levels_due.delete();
      mismatches = 0;
      words_checked = 0;
    endfunction

    function void set_reg(logic [ed_pkg::CFG_IDX_W-1:0] idx,
                          logic [ed_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ed_pkg::CFG_ROW_WIDTH: width_reg = 32'(val);
        ed_pkg::CFG_CHANNEL_COUNT: chan_reg = 32'(val[2:0]);
        ed_pkg::CFG_MAX_LEVEL_A: max_reg[0] = 32'(val[7:0]);
        ed_pkg::CFG_MAX_LEVEL_B: max_reg[1] = 32'(val[7:0]);
        ed_pkg::CFG_MAX_LEVEL_C: max_reg[2] = 32'(val[7:0]);
        ed_pkg::CFG_MAX_LEVEL_D: max_reg[3] = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function void note_input(ed_pkg::in_word_t w);
      int unsigned width, nch, col, m, lvl, recon;
      bit final_row, last;
      bit [15:0] acc, eu;
      bit [15:0] prev_w [4];
      bit [15:0] nbl_w [4];
      bit [15:0] nbp_w [4];
      bit [15:0] rc_w [4];
      bit [15:0] smp [4];
      bit [7:0] lv [4];
      longint target, err;
      ed_pkg::out_word_t o;
      width = (width_reg < 1) ? 1 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
      nch = (chan_reg < 1) ? 1 : (chan_reg > 4 ? 4 : chan_reg);
      col = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
      final_row = w.in_final_row;
      last = (col + 1 >= width);
      smp = '{w.sample_a, w.sample_b, w.sample_c, w.sample_d};
      for (int c = 0; c < 4; c++) begin
        prev_w[c] = '0; nbl_w[c] = '0; nbp_w[c] = '0; rc_w[c] = '0; lv[c] = '0;
        if (c < nch) begin
          acc = err_line[col][c] + carry_right[c];
          target = longint'(smp[c]) + (longint'($signed(acc)) >>> 4);
          m = (max_reg[c] == 0) ? 1 : max_reg[c];
          if (target < 0) lvl = 0;
          else if (target > 65535) lvl = m;
          else lvl = 32'((2 * longint'(target) * m + 65535) / 131070);
          recon = (2 * lvl * 65535 + m) / (2 * m);
          err = target - longint'(recon);
          eu = err[15:0];
          lv[c] = lvl[7:0];
          rc_w[c] = eu * 16'd7;
          if (!final_row) begin
            prev_w[c] = part_below_left[c] + eu * 16'd3;
            nbl_w[c] = part_below[c] + eu * 16'd5;
            nbp_w[c] = eu;
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        if (col > 0) err_line[col-1][c] = final_row ? 16'd0 : prev_w[c];
        if (final_row) err_line[col][c] = '0;
        if (last) begin
          if (!final_row) err_line[col][c] = nbl_w[c];
          carry_right[c] = '0; part_below_left[c] = '0; part_below[c] = '0;
        end else begin
          carry_right[c] = rc_w[c];
          part_below_left[c] = final_row ? 16'd0 : nbl_w[c];
          part_below[c] = final_row ? 16'd0 : nbp_w[c];
        end
      end
      col_pos = last ? 0 : col + 1;
      o.level_a = lv[0]; o.level_b = lv[1]; o.level_c = lv[2]; o.level_d = lv[3];
      o.row_end = last;
      levels_due.push_back(o);
    endfunction

    function void check_result(ed_pkg::out_word_t got);
      ed_pkg::out_word_t exp_w;
      words_checked++;
      if (levels_due.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
        return;
      end
      exp_w = levels_due.pop_front();
      if (got.level_a !== exp_w.level_a) begin
        $error("level_a expected %0d got %0d", exp_w.level_a, got.level_a); mismatches++;
      end
      if (got.level_b !== exp_w.level_b) begin
        $error("level_b expected %0d got %0d", exp_w.level_b, got.level_b); mismatches++;
      end
      if (got.level_c !== exp_w.level_c) begin
        $error("level_c expected %0d got %0d", exp_w.level_c, got.level_c); mismatches++;
      end
      if (got.level_d !== exp_w.level_d) begin
        $error("level_d expected %0d got %0d", exp_w.level_d, got.level_d); mismatches++;
      end
      if (got.row_end !== exp_w.row_end) begin
        $error("row_end expected %0d got %0d", exp_w.row_end, got.row_end); mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ed_pkg::CFG_IDX_W-1:0] cfg_index = ed_pkg::CFG_ROW_WIDTH;
  logic [ed_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ed_in_if in_ch ();
  ed_out_if out_ch ();

  error_diffusion_dither u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  dither_scoreboard sb = new();
  bit quiet_mode = 1'b0;
  bit hold_long = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned final_words = 0;
  int unsigned frames_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall bursts, one long hold on request.
  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_error_diffusion_dither NOT OK");
        $finish;
      end
    end
  end

  // Valid stays high after an accept; the next call either offers a new
  // word at once or drops valid for a burst, and drain() drops it at the end.
  task automatic send_pixel(ed_pkg::in_word_t w);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w);
    if (w.in_final_row) final_words++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [ed_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= ed_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, ed_pkg::CFG_DATA_W'(val));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.levels_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic ed_pkg::in_word_t rand_pixel(bit fin);
    ed_pkg::in_word_t w;
    int unsigned k;
    k = $urandom_range(0, 9);
    w.sample_a = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
    w.sample_b = 16'($urandom);
    w.sample_c = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
    w.sample_d = 16'($urandom);
    w.in_final_row = fin;
    return w;
  endfunction

  // One frame of rows rows at the given width, last row flagged.
  task automatic send_frame(int unsigned width, int unsigned rows);
    for (int r = 0; r < rows; r++)
      for (int x = 0; x < width; x++) send_pixel(rand_pixel(r == rows - 1));
    frames_sent++;
  endtask

  task automatic set_mode(int unsigned width, int unsigned nch, int unsigned m);
    drain();
    write_reg(ed_pkg::CFG_ROW_WIDTH, width);
    write_reg(ed_pkg::CFG_CHANNEL_COUNT, nch);
    write_reg(ed_pkg::CFG_MAX_LEVEL_A, m);
    write_reg(ed_pkg::CFG_MAX_LEVEL_B, $urandom_range(1, 255));
    write_reg(ed_pkg::CFG_MAX_LEVEL_C, (m == 255) ? 1 : 255);
    write_reg(ed_pkg::CFG_MAX_LEVEL_D, $urandom_range(0, 255));
  endtask

  initial begin
    ed_pkg::in_word_t w;
    sb.clear();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes at width 4 with four channels, then odd register values.
    set_mode(4, 4, 255);
    w = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 1'b0}; send_pixel(w);
    w = '{16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE, 1'b0}; send_pixel(w);
    w = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}; send_pixel(w);
    w = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0}; send_pixel(w);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(1'b1));
    // A flagged pixel mid-row, then a width shrunk mid-row.
    send_pixel(rand_pixel(1'b0));
    send_pixel(rand_pixel(1'b1));
    drain();
    write_reg(ed_pkg::CFG_ROW_WIDTH, 1);
    send_pixel(rand_pixel(1'b0));
    set_mode(0, 0, 0);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(i == 2));
    set_mode(8191, 7, 1);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(1'b1));
    // The column counter is mid-row here; wrap it back with a narrow width.
    drain();
    write_reg(ed_pkg::CFG_ROW_WIDTH, 2);
    send_pixel(rand_pixel(1'b1));

    // Random frames under varied settings.
    for (int f = 0; f < 20; f++) begin
      set_mode($urandom_range(1, 7), $urandom_range(1, 4),
               (f % 3 == 0) ? 255 : $urandom_range(1, 255));
      send_frame(sb.width_reg == 0 ? 1 : sb.width_reg, $urandom_range(2, 5));
      // A broken frame now and then: five pixels with random final-row flags.
      if (f % 4 == 1)
        for (int i = 0; i < 5; i++) send_pixel(rand_pixel(1'($urandom_range(0, 1))));
      if (f == 5) begin
        hold_long = 1'b1;
        for (int i = 0; i < 12; i++) send_pixel(rand_pixel(1'b0));
      end
    end
    // Twenty pixels at the largest width, then the end part with no idling.
    set_mode(4096, 4, 255);
    send_frame(20, 1);
    drain();
    quiet_mode = 1'b1;
    set_mode(6, 3, 200);
    send_frame(6, 4);
    drain();

    $display("Covered %0d result words over %0d frames, %0d final-row words.",
             sb.words_checked, frames_sent, final_words);
    if (sb.mismatches == 0 && sb.levels_due.size() == 0) begin
      $display("tb_error_diffusion_dither OK");
    end else begin
      $display("tb_error_diffusion_dither NOT OK");
    end
    $finish;
  end
endmodule
